[rtl/vrbs_pkg.sv]
// ----------------------------------------------------------------------------
// vrbs_pkg: shared types and constants of the record byte stack
// sizes of the byte memory, header and read window, command codes, status
// codes and the command word passed from the front end to the back end
// ----------------------------------------------------------------------------
package vrbs_pkg;

  // storage geometry
  localparam int STACK_BYTES  = 1024;
  localparam int HEADER_BYTES = 4;
  localparam int MAX_READ     = 64;

  // fixed field widths
  localparam int REC_LEN_W = 10;
  localparam int REQ_W     = 7;
  localparam int BYTE_W    = 8;

  // derived widths
  localparam int AW     = $clog2(STACK_BYTES);         // memory address
  localparam int TW     = AW + 1;                      // top index, holds STACK_BYTES
  localparam int RA_W   = AW + 2;                      // read address, may run past the end
  localparam int CMP_W  = (TW > REC_LEN_W + 1) ? TW : REC_LEN_W + 1;
  localparam int LEN_W  = 8 * HEADER_BYTES;            // stored length word
  localparam int RW     = $clog2(MAX_READ + 1);        // read byte count
  localparam int HW     = $clog2(HEADER_BYTES + 1);    // header byte counter
  localparam int QDEPTH = 2;                           // command queue depth

  localparam logic [TW-1:0] TOP_RESET = TW'(STACK_BYTES);
  localparam logic [32:0]   HDR_CAP   = (33'd1 << (8 * HEADER_BYTES)) - 33'd1;

  // command codes
  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_PEEK  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  // status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  // decoded command
  typedef struct packed {
    op_e                  op;
    logic [BYTE_W-1:0]    data;
    logic                 first;
    logic                 last;
    logic                 bad_len;  // length zero or too big for the header
    logic [CMP_W-1:0]     need;     // record length plus header
    logic [REC_LEN_W-1:0] rlen;
    logic [RW-1:0]        req_n;    // request clipped to the read window
  } cmd_t;

endpackage

[rtl/vrbs_front.sv]
// ----------------------------------------------------------------------------
// vrbs_front: command decode
// classifies each input transaction and precomputes the state-free checks
// ----------------------------------------------------------------------------
module vrbs_front import vrbs_pkg::*; (
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           operation_i,
  input  logic [BYTE_W-1:0]    data_byte_i,
  input  logic                 first_byte_i,
  input  logic                 last_byte_i,
  input  logic [REC_LEN_W-1:0] record_length_i,
  input  logic [REQ_W-1:0]     request_length_i,
  output logic                 cmd_valid_o,
  output cmd_t                 cmd_o,
  input  logic                 cmd_ready_i
);

  logic bad_len;

  assign bad_len = (record_length_i == '0) || ({23'd0, record_length_i} > HDR_CAP);

  always_comb begin
    cmd_o.op      = op_e'(operation_i);
    cmd_o.data    = data_byte_i;
    cmd_o.first   = first_byte_i;
    cmd_o.last    = last_byte_i;
    cmd_o.bad_len = bad_len;
    cmd_o.need    = CMP_W'(record_length_i) + CMP_W'(HEADER_BYTES);
    cmd_o.rlen    = record_length_i;
    if (request_length_i > REQ_W'(MAX_READ)) begin
      cmd_o.req_n = RW'(MAX_READ);
    end else begin
      cmd_o.req_n = RW'(request_length_i);
    end
  end

  assign cmd_valid_o = in_valid_i;
  assign in_ready_o  = cmd_ready_i;

endmodule

[rtl/vrbs_queue.sv]
// ----------------------------------------------------------------------------
// vrbs_queue: command queue
// short fifo that decouples the decode front end from the back end
// ----------------------------------------------------------------------------
module vrbs_queue import vrbs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  input  cmd_t push_cmd_i,
  output logic push_ready_o,
  output logic pop_valid_o,
  output cmd_t pop_cmd_o,
  input  logic pop_ready_i
);

  localparam int QPW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW = $clog2(QDEPTH + 1);

  cmd_t           entry_q [QDEPTH];
  logic [QPW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0] count_q, count_d;
  logic           do_push, do_pop;

  assign push_ready_o = (count_q != QCW'(QDEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = entry_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

[rtl/vrbs_back.sv]
// ----------------------------------------------------------------------------
// vrbs_back: execution engine
// owns the byte memory and stack pointers, writes records and headers,
// reads headers and record bytes, and drives the result register
// ----------------------------------------------------------------------------
module vrbs_back import vrbs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  cmd_t              cmd_i,
  output logic              cmd_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              has_byte_o,
  output logic [1:0]        status_o,
  output logic              last_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HDR  = 3'd1;  // header write
  localparam logic [2:0] S_RDH  = 3'd2;  // header read
  localparam logic [2:0] S_CALC = 3'd3;  // byte count and pop update
  localparam logic [2:0] S_RDB  = 3'd4;  // byte stream
  localparam logic [2:0] S_RESP = 3'd5;  // single result

  localparam int SUM_W = ((LEN_W > TW) ? LEN_W : TW) + 2;

  logic [BYTE_W-1:0] mem [STACK_BYTES];

  logic [2:0]           state_q, state_d;
  logic [TW-1:0]        top_q, top_d;
  logic [TW-1:0]        wi_q, wi_d;
  logic [REC_LEN_W-1:0] pend_q, pend_d;
  logic                 refusing_q, refusing_d;
  logic [HW-1:0]        cnt_q, cnt_d;
  logic [RW-1:0]        idx_q, idx_d, idx_nx;
  logic [RW-1:0]        n_q, n_d, n_c;
  logic [LEN_W-1:0]     len_q, len_d;
  logic [RA_W-1:0]      base_q, base_d;
  logic [TW-1:0]        hbase_q, hbase_d;
  logic [1:0]           res_status_q, res_status_d;
  cmd_t                 cmd_q, cmd_d;

  logic                 out_valid_q;
  logic [BYTE_W-1:0]    out_byte_q;
  logic                 has_byte_q, last_q;
  logic [1:0]           status_q;

  logic [BYTE_W-1:0]    rd_data_q, rd_byte;
  logic                 rd_oob_q;

  logic                 we;
  logic [AW-1:0]        wa;
  logic [BYTE_W-1:0]    wd;
  logic [RA_W-1:0]      ra;

  logic                 can_emit, emit, e_has, e_last;
  logic [BYTE_W-1:0]    e_byte;
  logic [1:0]           e_status;

  logic [REC_LEN_W-1:0] p_pend;
  logic                 p_ref;
  logic [TW-1:0]        p_wi;
  logic [TW-1:0]        hdr_addr;
  logic [31:0]          hdr_word;
  logic [SUM_W-1:0]     pop_sum;

  assign can_emit = !out_valid_q || out_ready_i;
  assign rd_byte  = rd_oob_q ? '0 : rd_data_q;
  assign hdr_addr = hbase_q + TW'(cnt_q);
  assign hdr_word = 32'(pend_q) >> {cnt_q, 3'b000};
  assign pop_sum  = SUM_W'(top_q) + SUM_W'(HEADER_BYTES) + SUM_W'(len_q);

  always_comb begin
    state_d      = state_q;
    top_d        = top_q;
    wi_d         = wi_q;
    pend_d       = pend_q;
    refusing_d   = refusing_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    idx_nx       = idx_q;
    n_d          = n_q;
    n_c          = cmd_q.req_n;
    len_d        = len_q;
    base_d       = base_q;
    hbase_d      = hbase_q;
    res_status_d = res_status_q;
    cmd_d        = cmd_q;
    cmd_ready_o  = 1'b0;
    we           = 1'b0;
    wa           = '0;
    wd           = '0;
    ra           = '0;
    emit         = 1'b0;
    e_byte       = '0;
    e_has        = 1'b0;
    e_status     = STAT_OK;
    e_last       = 1'b0;
    p_pend       = pend_q;
    p_ref        = refusing_q;
    p_wi         = wi_q;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_ready_o = 1'b1;
          cmd_d       = cmd_i;
          if (cmd_i.op == OP_PUSH) begin
            if (cmd_i.first) begin
              p_pend = '0;
              p_ref  = 1'b0;
              if (cmd_i.bad_len || (CMP_W'(top_q) < cmd_i.need)) begin
                p_ref = 1'b1;
              end else begin
                p_pend = cmd_i.rlen;
                p_wi   = TW'(CMP_W'(top_q) - CMP_W'(cmd_i.rlen));
              end
            end
            res_status_d = p_ref ? STAT_FULL : STAT_OK;
            if ((p_pend != '0) && (p_wi < top_q)) begin
              we   = 1'b1;
              wa   = p_wi[AW-1:0];
              wd   = cmd_i.data;
              p_wi = p_wi + 1'b1;
            end
            wi_d       = p_wi;
            pend_d     = p_pend;
            refusing_d = p_ref;
            state_d    = S_RESP;
            if (cmd_i.last) begin
              if (p_pend != '0) begin
                hbase_d = TW'(CMP_W'(top_q) - CMP_W'(p_pend) - CMP_W'(HEADER_BYTES));
                cnt_d   = '0;
                state_d = S_HDR;
              end else begin
                pend_d     = '0;
                refusing_d = 1'b0;
              end
            end
          end else begin
            // any other command drops an open or refused record
            pend_d     = '0;
            refusing_d = 1'b0;
            if (cmd_i.op == OP_CLEAR) begin
              top_d        = TOP_RESET;
              res_status_d = STAT_OK;
              state_d      = S_RESP;
            end else if (top_q >= TOP_RESET) begin
              res_status_d = STAT_EMPTY;
              state_d      = S_RESP;
            end else begin
              cnt_d   = '0;
              len_d   = '0;
              state_d = S_RDH;
            end
          end
        end
      end

      S_HDR: begin
        we    = 1'b1;
        wa    = hdr_addr[AW-1:0];
        wd    = hdr_word[BYTE_W-1:0];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == HW'(HEADER_BYTES - 1)) begin
          top_d      = hbase_q;
          pend_d     = '0;
          refusing_d = 1'b0;
          state_d    = S_RESP;
        end
      end

      S_RDH: begin
        ra = RA_W'(top_q) + RA_W'(cnt_q);
        if (cnt_q != '0) begin
          // least significant byte first, shifted in from the top
          len_d = LEN_W'({rd_byte, len_q} >> BYTE_W);
        end
        if (cnt_q == HW'(HEADER_BYTES)) begin
          state_d = S_CALC;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      S_CALC: begin
        if (LEN_W'(cmd_q.req_n) > len_q) begin
          n_c = RW'(len_q);
        end
        ra     = RA_W'(top_q) + RA_W'(HEADER_BYTES);
        base_d = RA_W'(top_q) + RA_W'(HEADER_BYTES);
        if (cmd_q.op == OP_POP) begin
          top_d = (pop_sum > SUM_W'(STACK_BYTES)) ? TOP_RESET : TW'(pop_sum);
        end
        if (n_c == '0) begin
          res_status_d = STAT_OK;
          state_d      = S_RESP;
        end else begin
          n_d     = n_c;
          idx_d   = '0;
          state_d = S_RDB;
        end
      end

      S_RDB: begin
        if (can_emit) begin
          emit   = 1'b1;
          e_byte = rd_byte;
          e_has  = 1'b1;
          e_last = (idx_q == RW'(n_q - 1'b1));
          if (e_last) begin
            state_d = S_IDLE;
          end else begin
            idx_nx = idx_q + 1'b1;
          end
        end
        idx_d = idx_nx;
        // prefetch the byte that will be sent next
        ra = base_q + RA_W'(idx_nx);
      end

      S_RESP: begin
        if (can_emit) begin
          emit     = 1'b1;
          e_status = res_status_q;
          e_last   = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      top_q       <= TOP_RESET;
      wi_q        <= '0;
      pend_q      <= '0;
      refusing_q  <= 1'b0;
      cnt_q       <= '0;
      idx_q       <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      top_q      <= top_d;
      wi_q       <= wi_d;
      pend_q     <= pend_d;
      refusing_q <= refusing_d;
      cnt_q      <= cnt_d;
      idx_q      <= idx_d;
      n_q        <= n_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    len_q        <= len_d;
    base_q       <= base_d;
    hbase_q      <= hbase_d;
    res_status_q <= res_status_d;
    cmd_q        <= cmd_d;
    if (emit) begin
      out_byte_q <= e_byte;
      has_byte_q <= e_has;
      status_q   <= e_status;
      last_q     <= e_last;
    end
  end

  // byte memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_q <= mem[ra[AW-1:0]];
    rd_oob_q  <= (ra >= RA_W'(STACK_BYTES));
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign has_byte_o  = has_byte_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

  a_top_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= TOP_RESET)
    else $error("top index beyond the stack");

  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == S_IDLE || state_q == S_HDR))
    else $error("memory write outside push or header write");

  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RDB) |-> (idx_q < n_q))
    else $error("byte index past the count");

  a_open_or_refuse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((pend_q != '0) && refusing_q))
    else $error("record both open and refused");

endmodule

[rtl/variable_record_byte_stack.sv]
// ----------------------------------------------------------------------------
// variable_record_byte_stack: stack of variable-length byte records
// front end decode, two-entry command queue and a back end that owns the
// 1024-byte record memory and drives a registered result port
// ----------------------------------------------------------------------------
// records live in one 1024 x 8 memory that grows downward, each stored as
// its data bytes with a four-byte length header below them. a push byte is
// executed in the back end and then answered with a result; the byte that
// closes a record first writes the header through the single write port
// one byte at a time. pop and peek go through a start step, a header fetch
// through the registered read port and a byte count step, then stream one
// record byte per cycle while the receiver is ready (at most 64), or give a
// single result when there is nothing to send; clear and an empty stack
// answer with a single result. the command queue registers each command and
// lets new transactions be taken while the back end is busy. the memory has
// no reset and no clearing pass, so the block is ready right after reset
module variable_record_byte_stack import vrbs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           operation_i,
  input  logic [BYTE_W-1:0]    data_byte_i,
  input  logic                 first_byte_i,
  input  logic                 last_byte_i,
  input  logic [REC_LEN_W-1:0] record_length_i,
  input  logic [REQ_W-1:0]     request_length_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [BYTE_W-1:0]    out_byte_o,
  output logic                 has_byte_o,
  output logic [1:0]           status_o,
  output logic                 last_o
);

  // decoded transaction into the queue
  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  // queue head into the back end
  logic q_valid, q_ready;
  cmd_t q_cmd;

  // classify each transaction and do the length checks that need no state
  vrbs_front u_front (
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation_i),
    .data_byte_i      (data_byte_i),
    .first_byte_i     (first_byte_i),
    .last_byte_i      (last_byte_i),
    .record_length_i  (record_length_i),
    .request_length_i (request_length_i),
    .cmd_valid_o      (cmd_valid),
    .cmd_o            (cmd),
    .cmd_ready_i      (cmd_ready)
  );

  // short queue so the front end keeps taking transactions during long pops
  vrbs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (cmd_valid),
    .push_cmd_i   (cmd),
    .push_ready_o (cmd_ready),
    .pop_valid_o  (q_valid),
    .pop_cmd_o    (q_cmd),
    .pop_ready_i  (q_ready)
  );

  // memory, stack pointers and result register
  vrbs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_ready_o (q_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .has_byte_o  (has_byte_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule

[dv/tb_variable_record_byte_stack.sv]
// ----------------------------------------------------------------------------
// tb_variable_record_byte_stack: self-checking bench for the record byte stack
// a directed table walks the empty, full and interrupted-record cases, then
// random traffic mixes pushed records, pops, peeks, clears and noise; every
// result transaction is checked in order against a typed-in status or a behavioral stack model
// ----------------------------------------------------------------------------
module tb_variable_record_byte_stack;
  import vrbs_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RANDOM_ITEMS = 320;
  localparam int DRAIN_CYCLES = 100;   // header fetch plus a full 64-byte read
  localparam int DIR_ROWS     = 27;
  localparam int PRINT_CAP    = 100;

  // one input transaction; fixed rows carry a typed-in status instead of
  // the model's answer (always a single result with no byte)
  typedef struct {
    op_e                  op;
    logic [BYTE_W-1:0]    data;
    logic                 first;
    logic                 lastb;
    logic [REC_LEN_W-1:0] rlen;
    logic [REQ_W-1:0]     req;
    bit                   fixed;
    logic [1:0]           fx_st;
  } stim_t;

  // one result transaction
  typedef struct {
    logic [BYTE_W-1:0] out_data;
    logic              has_data;
    logic [1:0]        status;
    logic              is_last;
  } result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [1:0]           operation_i;
  logic [BYTE_W-1:0]    data_byte_i;
  logic                 first_byte_i;
  logic                 last_byte_i;
  logic [REC_LEN_W-1:0] record_length_i;
  logic [REQ_W-1:0]     request_length_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [BYTE_W-1:0]    out_byte_o;
  logic                 has_byte_o;
  logic [1:0]           status_o;
  logic                 last_o;

  // typed-in expectation that travels with the transaction on the bus
  bit                   cur_fixed;
  logic [1:0]           cur_fixed_st;

  // stack model state
  logic [BYTE_W-1:0]    model_mem [STACK_BYTES];
  bit                   model_written [STACK_BYTES];
  int unsigned          model_top;
  int unsigned          model_wr;
  int unsigned          model_open_len;
  bit                   model_refusing;

  result_t              awaited_results [$];
  int                   mismatch_count;
  int                   items_sent;
  int                   burst_left;

  // receiver stall pattern
  logic [15:0]          ready_pattern;
  bit   [3:0]           pattern_pos;
  int                   pattern_age;

  stim_t                dir_tab [DIR_ROWS];

  variable_record_byte_stack uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation_i),
    .data_byte_i      (data_byte_i),
    .first_byte_i     (first_byte_i),
    .last_byte_i      (last_byte_i),
    .record_length_i  (record_length_i),
    .request_length_i (request_length_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_byte_o       (out_byte_o),
    .has_byte_o       (has_byte_o),
    .status_o         (status_o),
    .last_o           (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  initial begin
    #(CLK_PERIOD * 3000000);
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stack model
  // ---------------------------------------------------------------------------

  // reads past the end of the memory give zero
  function automatic logic [BYTE_W-1:0] stored_byte(input int unsigned addr);
    return (addr < STACK_BYTES) ? model_mem[addr] : '0;
  endfunction

  // length word in the header of the top record, low byte first
  function automatic int unsigned top_record_length();
    int unsigned len;
    len = 0;
    for (int i = 0; i < HEADER_BYTES; i++)
      len |= int'(stored_byte(model_top + i)) << (8 * i);
    return len;
  endfunction

  // applies one accepted transaction to the model and queues its results
  function automatic void apply_stack_command(input op_e op, input logic [BYTE_W-1:0] data,
                                              input logic first, input logic lastb,
                                              input logic [REC_LEN_W-1:0] rlen,
                                              input logic [REQ_W-1:0] req,
                                              input bit fixed, input logic [1:0] fixed_st);
    result_t     batch [$];
    int unsigned rec_len;
    int unsigned count;
    int unsigned base;
    longint      new_top;
    logic [1:0]  st;
    st = STAT_OK;
    if (op == OP_PUSH) begin
      if (first) begin
        // a new first byte drops whatever record was open
        model_open_len = 0;
        model_refusing = 1'b0;
        if (rlen == 0 || 33'(rlen) > HDR_CAP || model_top < rlen + HEADER_BYTES) begin
          model_refusing = 1'b1;
        end else begin
          model_open_len = rlen;
          model_wr       = model_top - rlen;
        end
      end
      if (model_refusing) st = STAT_FULL;
      // bytes past the declared length fall on the old top and are dropped
      if (model_open_len != 0 && model_wr < model_top && model_wr < STACK_BYTES) begin
        model_mem[model_wr]     = data;
        model_written[model_wr] = 1'b1;
        model_wr++;
      end
      if (lastb) begin
        // header goes below the data, declared length even for a short record
        if (model_open_len != 0) begin
          base = model_top - model_open_len - HEADER_BYTES;
          for (int i = 0; i < HEADER_BYTES; i++) begin
            if (base + i < STACK_BYTES) begin
              model_mem[base + i]     = BYTE_W'(model_open_len >> (8 * i));
              model_written[base + i] = 1'b1;
            end
          end
          model_top = base;
        end
        model_open_len = 0;
        model_refusing = 1'b0;
      end
      batch.push_back('{8'h00, 1'b0, st, 1'b1});
    end else begin
      // any other command silently abandons an open or refused record
      model_open_len = 0;
      model_refusing = 1'b0;
      if (op == OP_CLEAR) begin
        model_top = STACK_BYTES;
        batch.push_back('{8'h00, 1'b0, STAT_OK, 1'b1});
      end else if (model_top >= STACK_BYTES) begin
        batch.push_back('{8'h00, 1'b0, STAT_EMPTY, 1'b1});
      end else begin
        rec_len = top_record_length();
        count   = req;
        if (count > rec_len) count = rec_len;
        if (count > MAX_READ) count = MAX_READ;
        if (count == 0) begin
          batch.push_back('{8'h00, 1'b0, STAT_OK, 1'b1});
        end else begin
          for (int unsigned i = 0; i < count; i++)
            batch.push_back('{stored_byte(model_top + HEADER_BYTES + i), 1'b1, STAT_OK,
                              logic'(i + 1 == count)});
        end
        if (op == OP_POP) begin
          new_top   = longint'(model_top) + HEADER_BYTES + rec_len;
          model_top = (new_top > STACK_BYTES) ? STACK_BYTES : int'(new_top);
        end
      end
    end
    if (fixed) begin
      awaited_results.push_back('{8'h00, 1'b0, fixed_st, 1'b1});
    end else begin
      foreach (batch[i]) awaited_results.push_back(batch[i]);
    end
  endfunction

  task automatic report_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("mismatch at %0t: %s is %h, expected %h", $time, field, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // scoreboard: model update on each input transaction, in-order compare on
  // each result transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : scoreboard
    result_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        apply_stack_command(op_e'(operation_i), data_byte_i, first_byte_i, last_byte_i,
                            record_length_i, request_length_i, cur_fixed, cur_fixed_st);
      if (out_valid_o && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unawaited result, out_byte", out_byte_o, 8'h00);
        end else begin
          want = awaited_results.pop_front();
          if (out_byte_o !== want.out_data) report_mismatch("out_byte", out_byte_o, want.out_data);
          if (has_byte_o !== want.has_data)
            report_mismatch("has_byte", 8'(has_byte_o), 8'(want.has_data));
          if (status_o !== want.status)
            report_mismatch("status", 8'(status_o), 8'(want.status));
          if (last_o !== want.is_last)
            report_mismatch("last", 8'(last_o), 8'(want.is_last));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: ready follows a 16-bit pattern that is swapped now and then,
  // sometimes for a stretch with no stalls at all
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (pattern_age == 0) begin
      ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      pattern_age   = $urandom_range(16, 80);
    end else begin
      pattern_age--;
    end
    out_ready_i <= ready_pattern[pattern_pos];
    pattern_pos++;
  end

  // ---------------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------------

  // drives one transaction and returns at the falling edge after it is taken;
  // transactions go out in bursts with random gaps in between
  task automatic send_item(input stim_t s);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i       <= 1'b1;
    operation_i      <= s.op;
    data_byte_i      <= s.data;
    first_byte_i     <= s.first;
    last_byte_i      <= s.lastb;
    record_length_i  <= s.rlen;
    request_length_i <= s.req;
    cur_fixed        <= s.fixed;
    cur_fixed_st     <= s.fx_st;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  // every field random, checked against the model
  function automatic stim_t random_stim(input op_e op);
    stim_t s;
    s = '{op, BYTE_W'($urandom), 1'($urandom), 1'($urandom), REC_LEN_W'($urandom),
          REQ_W'($urandom), 1'b0, STAT_OK};
    return s;
  endfunction

  // pushes nbytes bytes under one first byte; close marks the final one last
  task automatic push_record(input int unsigned rlen, input int unsigned nbytes,
                             input bit close);
    stim_t s;
    for (int unsigned i = 0; i < nbytes; i++) begin
      s       = random_stim(OP_PUSH);
      s.first = (i == 0);
      s.lastb = close && (i + 1 == nbytes);
      if (i == 0) s.rlen = rlen;
      send_item(s);
    end
  endtask

  // pop or peek; the request is pulled back when it would reach a byte of
  // the top record that no push ever wrote
  task automatic send_read(input op_e op);
    stim_t       s;
    int unsigned window;
    int unsigned safe;
    s = random_stim(op);
    case ($urandom_range(0, 2))
      0:       s.req = REQ_W'($urandom_range(0, 127));
      1:       s.req = REQ_W'($urandom_range(0, 8));
      default: s.req = REQ_W'($urandom_range(60, 127));
    endcase
    if (model_top < STACK_BYTES) begin
      window = top_record_length();
      if (window > MAX_READ) window = MAX_READ;
      safe = 0;
      while (safe < window && model_top + HEADER_BYTES + safe < STACK_BYTES &&
             model_written[model_top + HEADER_BYTES + safe])
        safe++;
      if (safe < window && s.req > safe) s.req = REQ_W'($urandom_range(0, safe));
    end
    send_item(s);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int          pick;
    int          sel;
    int unsigned rlen;
    int unsigned nbytes;
    stim_t       s;

    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    operation_i      = OP_PUSH;
    data_byte_i      = '0;
    first_byte_i     = 1'b0;
    last_byte_i      = 1'b0;
    record_length_i  = '0;
    request_length_i = '0;
    out_ready_i      = 1'b0;
    cur_fixed        = 1'b0;
    cur_fixed_st     = STAT_OK;
    ready_pattern    = 16'hFFFF;
    pattern_pos      = '0;
    pattern_age      = 0;
    mismatch_count   = 0;
    items_sent       = 0;
    burst_left       = 0;
    model_top        = STACK_BYTES;
    model_wr         = 0;
    model_open_len   = 0;
    model_refusing   = 1'b0;
    foreach (model_mem[i]) begin
      model_mem[i]     = '0;
      model_written[i] = 1'b0;
    end

    // directed table: op, data, first, last, length, request, fixed, status
    dir_tab = '{
      // empty stack after reset
      '{OP_POP,  8'h00, 1'b0, 1'b0, 10'd0,    7'd0,   1'b1, STAT_EMPTY},
      '{OP_PEEK, 8'h00, 1'b0, 1'b0, 10'd0,    7'd127, 1'b1, STAT_EMPTY},
      // stray byte with nothing open
      '{OP_PUSH, 8'hFF, 1'b0, 1'b0, 10'd0,    7'd0,   1'b1, STAT_OK},
      // zero length is refused, the rest of that record too
      '{OP_PUSH, 8'h00, 1'b1, 1'b0, 10'd0,    7'd0,   1'b1, STAT_FULL},
      '{OP_PUSH, 8'h5A, 1'b0, 1'b0, 10'd0,    7'd0,   1'b1, STAT_FULL},
      '{OP_PUSH, 8'hA5, 1'b0, 1'b1, 10'd0,    7'd0,   1'b1, STAT_FULL},
      // largest length field never fits
      '{OP_PUSH, 8'hA5, 1'b1, 1'b1, 10'd1023, 7'd0,   1'b1, STAT_FULL},
      // 1020 bytes fit exactly; short record, only its first byte is written
      '{OP_PUSH, 8'hFF, 1'b1, 1'b1, 10'd1020, 7'd0,   1'b1, STAT_OK},
      '{OP_PEEK, 8'h00, 1'b0, 1'b0, 10'd0,    7'd1,   1'b0, STAT_OK},
      // zero request: nothing to send, record still discarded
      '{OP_POP,  8'h00, 1'b0, 1'b0, 10'd0,    7'd0,   1'b1, STAT_OK},
      // well-formed three-byte record
      '{OP_PUSH, 8'h00, 1'b1, 1'b0, 10'd3,    7'd0,   1'b1, STAT_OK},
      '{OP_PUSH, 8'h80, 1'b0, 1'b0, 10'd0,    7'd0,   1'b1, STAT_OK},
      '{OP_PUSH, 8'h7F, 1'b0, 1'b1, 10'd0,    7'd0,   1'b1, STAT_OK},
      // two-byte record with two extra bytes
      '{OP_PUSH, 8'h11, 1'b1, 1'b0, 10'd2,    7'd0,   1'b1, STAT_OK},
      '{OP_PUSH, 8'h22, 1'b0, 1'b0, 10'd0,    7'd0,   1'b1, STAT_OK},
      '{OP_PUSH, 8'h33, 1'b0, 1'b0, 10'd0,    7'd0,   1'b1, STAT_OK},
      '{OP_PUSH, 8'h44, 1'b0, 1'b1, 10'd0,    7'd0,   1'b1, STAT_OK},
      '{OP_PEEK, 8'h00, 1'b0, 1'b0, 10'd0,    7'd64,  1'b0, STAT_OK},
      '{OP_POP,  8'h00, 1'b0, 1'b0, 10'd0,    7'd127, 1'b0, STAT_OK},
      // first byte while a record is open restarts it
      '{OP_PUSH, 8'h55, 1'b1, 1'b0, 10'd5,    7'd0,   1'b1, STAT_OK},
      '{OP_PUSH, 8'h66, 1'b1, 1'b1, 10'd1,    7'd0,   1'b1, STAT_OK},
      // peek in the middle of a record abandons it
      '{OP_PUSH, 8'h01, 1'b1, 1'b0, 10'd4,    7'd127, 1'b1, STAT_OK},
      '{OP_PEEK, 8'h00, 1'b0, 1'b0, 10'd0,    7'd64,  1'b0, STAT_OK},
      '{OP_POP,  8'h00, 1'b0, 1'b0, 10'd0,    7'd64,  1'b0, STAT_OK},
      '{OP_POP,  8'h00, 1'b0, 1'b0, 10'd0,    7'd64,  1'b0, STAT_OK},
      // clear while a record is open
      '{OP_PUSH, 8'hAA, 1'b1, 1'b0, 10'd2,    7'd0,   1'b1, STAT_OK},
      '{OP_CLEAR, 8'h00, 1'b0, 1'b0, 10'd0,   7'd0,   1'b1, STAT_OK}
    };

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) send_item(dir_tab[i]);

    // random traffic, mostly well-formed records with the odd broken one
    while (items_sent < DIR_ROWS + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        sel  = $urandom_range(0, 19);
        rlen = (sel < 14) ? $urandom_range(1, 16) :
               (sel < 18) ? $urandom_range(17, 80) : $urandom_range(81, 1020);
        // long declared lengths are sent short to keep the run brief
        nbytes = (rlen > 80) ? $urandom_range(1, 12) : rlen;
        sel    = $urandom_range(0, 9);
        if (sel == 0 && nbytes > 1) nbytes = $urandom_range(1, nbytes - 1);
        else if (sel == 1)          nbytes += $urandom_range(1, 3);
        push_record(rlen, nbytes, 1'b1);
      end else if (pick < 60) begin
        send_read(OP_POP);
      end else if (pick < 75) begin
        send_read(OP_PEEK);
      end else if (pick < 79) begin
        send_item(random_stim(OP_CLEAR));
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            // stray byte
            s       = random_stim(OP_PUSH);
            s.first = 1'b0;
            send_item(s);
          end
          1: begin
            // first byte with any length at all
            s       = random_stim(OP_PUSH);
            s.first = 1'b1;
            s.rlen  = REC_LEN_W'($urandom_range(0, 1023));
            send_item(s);
          end
          default: begin
            // record left open, whatever comes next cuts it off
            push_record($urandom_range(1, 20), $urandom_range(1, 6), 1'b0);
          end
        endcase
      end
    end

    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
